FILE: design/htfc_pkg.sv
`timescale 1ns / 1ps

package htfc_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TEMP_CRC = 2'd1;
    localparam logic [1:0] ST_HUM_CRC  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_TEMP_MIN = 2'd1;
    localparam logic [1:0] CFG_TEMP_MAX = 2'd2;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [7:0]  TEMP_SCALE  = 8'd175;
    localparam logic [7:0]  HUM_SCALE   = 8'd100;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;
    localparam logic [8:0]  TEMP_OFFSET = 9'd45;
    localparam logic [7:0]  TEMP_SPAN   = 8'd175;
    localparam logic [6:0]  HUM_SPAN    = 7'd100;

    localparam logic [7:0] INTERVAL_RESET = 8'd10;
    localparam logic [8:0] TEMP_MIN_RESET = 9'h1EC;
    localparam logic [8:0] TEMP_MAX_RESET = 9'd125;

    // What one lane hands to the merge stage.
    typedef struct packed {
        logic       crc_ok;
        logic [7:0] value;
    } t_lane_res;

    // One byte of the CRC-8, MSB first.
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

FILE: design/humidity_temp_frame_checker.sv
`timescale 1ns / 1ps

// Checks one sensor readout per request: the temperature and humidity words each go through
// a lane of their own (CRC-8 over the two bytes, scaling to degrees or percent by a multiply
// and a divide by 65535), and a merge stage applies the temperature window, updates the
// stored values and the reading counter, and holds the result. A request is taken every
// cycle while o_in_stall is low; its result passes through the two lane stages
// (high-byte CRC and product, then low-byte CRC and quotient) and the merge register.
// A stalled result holds the output while up to two further requests are still taken.
// Configuration writes are always ready and take effect at once; write only while idle.
module humidity_temp_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_temp_word,
    input  logic [7:0]  i_temp_crc,
    input  logic [15:0] i_hum_word,
    input  logic [7:0]  i_hum_crc,
    input  logic        i_link_connected,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [8:0]  o_temperature_deg,
    output logic [6:0]  o_humidity_pct,
    output logic        o_report_due,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    logic [7:0] r_report_interval;
    logic [8:0] r_temp_min;
    logic [8:0] r_temp_max;

    logic r_v1;
    logic r_v2;
    logic r_link1;
    logic r_link2;

    logic w_accept;
    logic w_adv2;
    logic w_taken;

    htfc_pkg::t_lane_res w_temp_res;
    htfc_pkg::t_lane_res w_hum_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_interval <= htfc_pkg::INTERVAL_RESET;
            r_temp_min        <= htfc_pkg::TEMP_MIN_RESET;
            r_temp_max        <= htfc_pkg::TEMP_MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                htfc_pkg::CFG_INTERVAL: r_report_interval <= i_cfg_data[7:0];
                htfc_pkg::CFG_TEMP_MIN: r_temp_min        <= i_cfg_data;
                htfc_pkg::CFG_TEMP_MAX: r_temp_max        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage moves forward when the one after it is empty or moving too.
    assign w_adv2     = r_v1 && (!r_v2 || w_taken);
    assign o_in_stall = r_v1 && !(!r_v2 || w_taken);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_accept) begin
                r_v1 <= 1'b1;
            end else if (w_adv2) begin
                r_v1 <= 1'b0;
            end
            if (w_adv2) begin
                r_v2 <= 1'b1;
            end else if (w_taken) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_link1 <= i_link_connected;
        end
        if (w_adv2) begin
            r_link2 <= r_link1;
        end
    end

    htfc_lane u_temp_lane (
        .i_clk   (i_clk),
        .i_load1 (w_accept),
        .i_load2 (w_adv2),
        .i_word  (i_temp_word),
        .i_crc   (i_temp_crc),
        .i_scale (htfc_pkg::TEMP_SCALE),
        .o_res   (w_temp_res)
    );

    htfc_lane u_hum_lane (
        .i_clk   (i_clk),
        .i_load1 (w_accept),
        .i_load2 (w_adv2),
        .i_word  (i_hum_word),
        .i_crc   (i_hum_crc),
        .i_scale (htfc_pkg::HUM_SCALE),
        .o_res   (w_hum_res)
    );

    htfc_merge u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (r_v2),
        .o_taken           (w_taken),
        .i_temp            (w_temp_res),
        .i_hum             (w_hum_res),
        .i_link            (r_link2),
        .i_interval        (r_report_interval),
        .i_temp_min        (r_temp_min),
        .i_temp_max        (r_temp_max),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_temperature_deg (o_temperature_deg),
        .o_humidity_pct    (o_humidity_pct),
        .o_report_due      (o_report_due)
    );

endmodule

FILE: design/htfc_lane.sv
`timescale 1ns / 1ps

module htfc_lane (
    input  logic                 i_clk,
    input  logic                 i_load1,
    input  logic                 i_load2,
    input  logic [15:0]          i_word,
    input  logic [7:0]           i_crc,
    input  logic [7:0]           i_scale,
    output htfc_pkg::t_lane_res  o_res
);

    logic [7:0]  r_crc_hi;
    logic [7:0]  r_lo;
    logic [7:0]  r_crc_rx;
    logic [23:0] r_prod;
    logic        r_ok;
    logic [7:0]  r_value;

    logic [23:0] w_prod;
    logic [7:0]  w_q0;
    logic [16:0] w_rem;
    logic [7:0]  w_q;

    assign w_prod = 24'(i_word) * 24'(i_scale);

    // p / 65535 = (p >> 16) plus one when (p & 0xFFFF) + (p >> 16) reaches 65535;
    // that sum stays below twice the divisor, so one correction is enough.
    assign w_q0  = r_prod[23:16];
    assign w_rem = {1'b0, r_prod[15:0]} + {9'd0, w_q0};
    assign w_q   = w_q0 + {7'd0, (w_rem >= htfc_pkg::FULL_SCALE)};

    always_ff @(posedge i_clk) begin
        if (i_load1) begin
            r_crc_hi <= htfc_pkg::crc_byte(htfc_pkg::CRC_INIT, i_word[15:8]);
            r_lo     <= i_word[7:0];
            r_crc_rx <= i_crc;
            r_prod   <= w_prod;
        end
        if (i_load2) begin
            r_ok    <= (htfc_pkg::crc_byte(r_crc_hi, r_lo) == r_crc_rx);
            r_value <= w_q;
        end
    end

    assign o_res.crc_ok = r_ok;
    assign o_res.value  = r_value;

endmodule

FILE: design/htfc_merge.sv
`timescale 1ns / 1ps

module htfc_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_taken,
    input  htfc_pkg::t_lane_res i_temp,
    input  htfc_pkg::t_lane_res i_hum,
    input  logic                i_link,
    input  logic [7:0]          i_interval,
    input  logic [8:0]          i_temp_min,
    input  logic [8:0]          i_temp_max,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [8:0]          o_temperature_deg,
    output logic [6:0]          o_humidity_pct,
    output logic                o_report_due
);

    logic       r_out_valid;
    logic [1:0] r_status;
    logic       r_due;
    logic [7:0] r_stored_temp;
    logic [6:0] r_stored_hum;
    logic [7:0] r_counter;

    logic [1:0] n_status;
    logic       n_due;
    logic [7:0] n_stored_temp;
    logic [6:0] n_stored_hum;
    logic [7:0] n_counter;

    logic signed [8:0] w_t_deg;
    logic [7:0]        w_cnt_inc;
    logic              w_in_window;

    assign o_taken   = i_valid && (!r_out_valid || !i_out_stall);
    assign w_t_deg   = $signed({1'b0, i_temp.value}) - $signed(htfc_pkg::TEMP_OFFSET);
    assign w_cnt_inc = r_counter + 8'd1;
    assign w_in_window = !((w_t_deg < $signed(i_temp_min)) || (w_t_deg > $signed(i_temp_max)));

    always_comb begin
        n_status      = htfc_pkg::ST_TEMP_CRC;
        n_due         = 1'b0;
        n_stored_temp = r_stored_temp;
        n_stored_hum  = r_stored_hum;
        n_counter     = r_counter;
        if (i_temp.crc_ok) begin
            n_stored_temp = i_temp.value;
            if (!i_hum.crc_ok) begin
                n_status = htfc_pkg::ST_HUM_CRC;
            end else begin
                n_stored_hum = i_hum.value[6:0];
                if (!w_in_window) begin
                    n_status = htfc_pkg::ST_RANGE;
                end else begin
                    n_status  = htfc_pkg::ST_OK;
                    n_counter = w_cnt_inc;
                    if (i_link && (w_cnt_inc == i_interval)) begin
                        n_counter = 8'd0;
                        n_due     = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_due         <= 1'b0;
            r_stored_temp <= 8'd0;
            r_stored_hum  <= 7'd0;
            r_counter     <= 8'd0;
        end else begin
            if (o_taken) begin
                r_out_valid   <= 1'b1;
                r_due         <= n_due;
                r_stored_temp <= n_stored_temp;
                r_stored_hum  <= n_stored_hum;
                r_counter     <= n_counter;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_taken) begin
            r_status <= n_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_report_due      = r_due;
    assign o_humidity_pct    = r_stored_hum;
    assign o_temperature_deg = $signed({1'b0, r_stored_temp}) - $signed(htfc_pkg::TEMP_OFFSET);

`ifndef ASSERT_OFF
    a_due_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_due) |-> (r_status == htfc_pkg::ST_OK))
        else $error("report flagged on a rejected reading");

    a_due_clears_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_due) |-> (r_counter == 8'd0))
        else $error("counter not cleared after a report");

    a_temp_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored_temp <= htfc_pkg::TEMP_SPAN)
        else $error("stored temperature beyond sensor span");

    a_hum_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored_hum <= htfc_pkg::HUM_SPAN)
        else $error("stored humidity beyond sensor span");

    a_counter_moves_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_counter != $past(r_counter)) |-> (r_out_valid && (r_status == htfc_pkg::ST_OK)))
        else $error("counter changed without an accepted reading");
`endif

endmodule
